### sv/radio_fifo_drain_sequencer_assert.svh
// Assertion macros for the receive FIFO drain sequencer checker.
`ifndef RADIO_FIFO_DRAIN_SEQUENCER_ASSERT_SVH
`define RADIO_FIFO_DRAIN_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define RFDS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define RFDS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/rfds_pkg.sv
// Package: types, codes and constants of the receive FIFO drain sequencer.
package rfds_pkg;

	localparam int FIFO_DEPTH = 256;

	// event codes
	localparam logic [2:0] FN_START  = 3'd0;
	localparam logic [2:0] FN_POLL   = 3'd1;
	localparam logic [2:0] FN_DONE   = 3'd2;
	localparam logic [2:0] FN_FINISH = 3'd3;
	localparam logic [2:0] FN_CANCEL = 3'd4;

	// result codes
	localparam logic [2:0] RES_IDLE    = 3'd0;
	localparam logic [2:0] RES_BUSY    = 3'd1;
	localparam logic [2:0] RES_NO_DATA = 3'd2;
	localparam logic [2:0] RES_READY   = 3'd3;
	localparam logic [2:0] RES_ERROR   = 3'd4;

	// frame kinds
	localparam logic [2:0] KIND_NONE      = 3'd0;
	localparam logic [2:0] KIND_IRQ_OP    = 3'd1;
	localparam logic [2:0] KIND_IRQ_RSP   = 3'd2;
	localparam logic [2:0] KIND_LVL_OP    = 3'd3;
	localparam logic [2:0] KIND_LVL_RSP   = 3'd4;
	localparam logic [2:0] KIND_FIFO_READ = 3'd5;

	// error codes
	localparam logic [3:0] ERR_NONE         = 4'd0;
	localparam logic [3:0] ERR_BUSY_TIMEOUT = 4'd1;
	localparam logic [3:0] ERR_IRQ_OP       = 4'd2;
	localparam logic [3:0] ERR_IRQ_RSP      = 4'd3;
	localparam logic [3:0] ERR_IRQ_STATUS   = 4'd4;
	localparam logic [3:0] ERR_LVL_OP       = 4'd5;
	localparam logic [3:0] ERR_LVL_RSP      = 4'd6;
	localparam logic [3:0] ERR_LVL_STATUS   = 4'd7;
	localparam logic [3:0] ERR_FIFO_RD      = 4'd8;
	localparam logic [3:0] ERR_FIFO_STATUS  = 4'd9;

	// register indexes
	localparam logic [2:0] REG_BUSY_TIMEOUT = 3'd0;
	localparam logic [2:0] REG_OP_IRQ       = 3'd1;
	localparam logic [2:0] REG_OP_LEVEL     = 3'd2;
	localparam logic [2:0] REG_OP_READ      = 3'd3;
	localparam logic [2:0] REG_IRQ_MASK     = 3'd4;
	localparam logic [2:0] REG_STATUS_OK    = 3'd5;
	localparam logic [2:0] REG_STATUS_DATA  = 3'd6;

	localparam logic [15:0] BUSY_TIMEOUT_RST = 16'd100;

	// frame lengths in bytes
	localparam logic [8:0] LEN_OP      = 9'd2;
	localparam logic [8:0] LEN_IRQ_RSP = 9'd6;
	localparam logic [8:0] LEN_LVL_RSP = 9'd4;

	typedef enum logic [12:0] {
		PH_IDLE         = 13'b0000000000001,
		PH_WAIT_IRQ_OP  = 13'b0000000000010,
		PH_IRQ_OP       = 13'b0000000000100,
		PH_WAIT_IRQ_RSP = 13'b0000000001000,
		PH_IRQ_RSP      = 13'b0000000010000,
		PH_WAIT_LVL_OP  = 13'b0000000100000,
		PH_LVL_OP       = 13'b0000001000000,
		PH_WAIT_LVL_RSP = 13'b0000010000000,
		PH_LVL_RSP      = 13'b0000100000000,
		PH_WAIT_FIFO    = 13'b0001000000000,
		PH_FIFO_RD      = 13'b0010000000000,
		PH_READY        = 13'b0100000000000,
		PH_ERROR        = 13'b1000000000000
	} phase_t;

	typedef struct packed {
		logic [15:0] busy_timeout;
		logic [15:0] op_irq;
		logic [15:0] op_level;
		logic [15:0] op_read;
		logic [31:0] irq_mask;
		logic [2:0]  status_ok;
		logic [2:0]  status_data;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] wait_start;
		logic        done;
		logic        ok;
		logic [2:0]  cap_status;
		logic [31:0] cap_word;
		logic [31:0] irq;
		logic [8:0]  level;
		logic        full;
		logic [3:0]  err;
	} state_t;

	typedef struct packed {
		logic [2:0]  code;
		logic        start;
		logic [2:0]  kind;
		logic [15:0] opcode;
		logic [8:0]  len;
		logic [3:0]  err;
		logic [8:0]  level;
		logic        full;
		logic [31:0] irq;
	} result_t;

endpackage

### sv/rfds_step.sv
// Next-state and result logic for one event of the drain sequencer.
module rfds_step import rfds_pkg::*; (
	input  cfg_t        cfg,
	input  state_t      st,
	input  logic [2:0]  func,
	input  logic        busy_level,
	input  logic [31:0] now_ms,
	input  logic        abort_request,
	input  logic        xfer_ok,
	input  logic [2:0]  cmd_status,
	input  logic [31:0] rx_word,
	output state_t      nxt,
	output result_t     res
);

	logic [31:0] elapsed;
	logic        timed_out;
	logic        status_good;
	logic [15:0] level_raw;
	logic        level_full;
	logic        active;
	logic        check_wait;
	logic        fresh;

	function automatic logic [2:0] view(input phase_t ph);
		logic [2:0] code;
		case (ph)
			PH_IDLE:  code = RES_IDLE;
			PH_READY: code = RES_READY;
			PH_ERROR: code = RES_ERROR;
			default:  code = RES_BUSY;
		endcase
		return code;
	endfunction

	assign elapsed     = now_ms - st.wait_start;
	assign timed_out   = elapsed > {16'd0, cfg.busy_timeout};
	assign status_good = (st.cap_status == cfg.status_ok) || (st.cap_status == cfg.status_data);
	assign level_raw   = st.cap_word[15:0];
	assign level_full  = level_raw >= 16'(FIFO_DEPTH);
	assign active      = (st.phase != PH_IDLE) && (st.phase != PH_READY) &&
	                     (st.phase != PH_ERROR);

	always_comb begin
		nxt        = st;
		res        = '0;
		res.code   = view(st.phase);
		check_wait = 1'b0;
		fresh      = 1'b0;
		case (func)
			FN_START: begin
				if (st.phase == PH_IDLE && !abort_request) begin
					nxt.irq        = '0;
					nxt.level      = '0;
					nxt.full       = 1'b0;
					nxt.err        = ERR_NONE;
					nxt.wait_start = now_ms;
					nxt.phase      = PH_WAIT_IRQ_OP;
					res.code       = RES_BUSY;
					res.start      = 1'b1;
				end
			end
			FN_POLL: begin
				if (abort_request && active) begin
					nxt.done  = 1'b0;
					nxt.ok    = 1'b0;
					nxt.phase = PH_IDLE;
					res.code  = RES_IDLE;
				end else begin
					case (st.phase)
						PH_WAIT_IRQ_OP, PH_WAIT_IRQ_RSP, PH_WAIT_LVL_OP,
						PH_WAIT_LVL_RSP, PH_WAIT_FIFO: begin
							check_wait = 1'b1;
						end
						PH_IRQ_OP: begin
							if (st.done) begin
								if (!st.ok) begin
									nxt.err   = ERR_IRQ_OP;
									nxt.phase = PH_ERROR;
									res.code  = RES_ERROR;
								end else begin
									nxt.wait_start = now_ms;
									nxt.phase      = PH_WAIT_IRQ_RSP;
									check_wait     = 1'b1;
									fresh          = 1'b1;
								end
							end
						end
						PH_IRQ_RSP: begin
							if (st.done) begin
								if (!st.ok) begin
									nxt.err   = ERR_IRQ_RSP;
									nxt.phase = PH_ERROR;
									res.code  = RES_ERROR;
								end else if (!status_good) begin
									nxt.err   = ERR_IRQ_STATUS;
									nxt.phase = PH_ERROR;
									res.code  = RES_ERROR;
								end else begin
									nxt.irq = st.cap_word;
									if ((st.cap_word & cfg.irq_mask) == '0) begin
										nxt.phase = PH_IDLE;
										res.code  = RES_NO_DATA;
									end else begin
										nxt.wait_start = now_ms;
										nxt.phase      = PH_WAIT_LVL_OP;
										check_wait     = 1'b1;
										fresh          = 1'b1;
									end
								end
							end
						end
						PH_LVL_OP: begin
							if (st.done) begin
								if (!st.ok) begin
									nxt.err   = ERR_LVL_OP;
									nxt.phase = PH_ERROR;
									res.code  = RES_ERROR;
								end else begin
									nxt.wait_start = now_ms;
									nxt.phase      = PH_WAIT_LVL_RSP;
									check_wait     = 1'b1;
									fresh          = 1'b1;
								end
							end
						end
						PH_LVL_RSP: begin
							if (st.done) begin
								if (!st.ok) begin
									nxt.err   = ERR_LVL_RSP;
									nxt.phase = PH_ERROR;
									res.code  = RES_ERROR;
								end else if (!status_good) begin
									nxt.err   = ERR_LVL_STATUS;
									nxt.phase = PH_ERROR;
									res.code  = RES_ERROR;
								end else if (level_raw == '0) begin
									nxt.phase = PH_IDLE;
									res.code  = RES_NO_DATA;
								end else begin
									nxt.full       = level_full;
									nxt.level      = level_full ? 9'(FIFO_DEPTH) : level_raw[8:0];
									nxt.wait_start = now_ms;
									nxt.phase      = PH_WAIT_FIFO;
									check_wait     = 1'b1;
									fresh          = 1'b1;
								end
							end
						end
						PH_FIFO_RD: begin
							if (st.done) begin
								if (!st.ok) begin
									nxt.err   = ERR_FIFO_RD;
									nxt.phase = PH_ERROR;
									res.code  = RES_ERROR;
								end else if (!status_good) begin
									nxt.err   = ERR_FIFO_STATUS;
									nxt.phase = PH_ERROR;
									res.code  = RES_ERROR;
								end else begin
									nxt.phase = PH_READY;
									res.code  = RES_READY;
								end
							end
						end
						default: begin
							// idle, ready, error: report the phase, nothing moves
						end
					endcase

					// wait phase: hold off on BUSY (error once the timeout passes), else post the next frame
					if (check_wait) begin
						if (busy_level) begin
							if (!fresh && timed_out) begin
								nxt.err   = ERR_BUSY_TIMEOUT;
								nxt.phase = PH_ERROR;
								res.code  = RES_ERROR;
							end else begin
								res.code = RES_BUSY;
							end
						end else begin
							nxt.done = 1'b0;
							nxt.ok   = 1'b0;
							res.code = RES_BUSY;
							case (nxt.phase)
								PH_WAIT_IRQ_OP: begin
									res.kind   = KIND_IRQ_OP;
									res.opcode = cfg.op_irq;
									res.len    = LEN_OP;
									nxt.phase  = PH_IRQ_OP;
								end
								PH_WAIT_IRQ_RSP: begin
									res.kind  = KIND_IRQ_RSP;
									res.len   = LEN_IRQ_RSP;
									nxt.phase = PH_IRQ_RSP;
								end
								PH_WAIT_LVL_OP: begin
									res.kind   = KIND_LVL_OP;
									res.opcode = cfg.op_level;
									res.len    = LEN_OP;
									nxt.phase  = PH_LVL_OP;
								end
								PH_WAIT_LVL_RSP: begin
									res.kind  = KIND_LVL_RSP;
									res.len   = LEN_LVL_RSP;
									nxt.phase = PH_LVL_RSP;
								end
								PH_WAIT_FIFO: begin
									res.kind   = KIND_FIFO_READ;
									res.opcode = cfg.op_read;
									res.len    = nxt.level + LEN_OP;
									nxt.phase  = PH_FIFO_RD;
								end
								default: begin
									res.kind = KIND_NONE;
								end
							endcase
						end
					end
				end
			end
			FN_DONE: begin
				nxt.ok         = xfer_ok;
				nxt.cap_status = cmd_status;
				nxt.cap_word   = rx_word;
				nxt.done       = 1'b1;
			end
			FN_FINISH: begin
				if (st.phase == PH_READY || st.phase == PH_ERROR) begin
					nxt.phase = PH_IDLE;
					res.code  = RES_IDLE;
				end
			end
			FN_CANCEL: begin
				nxt.done  = 1'b0;
				nxt.ok    = 1'b0;
				nxt.phase = PH_IDLE;
				res.code  = RES_IDLE;
			end
			default: begin
				// unknown event: phase is reported
			end
		endcase

		// held values as they stand after this event
		res.err   = nxt.err;
		res.level = nxt.level;
		res.full  = nxt.full;
		res.irq   = nxt.irq;
	end

endmodule

### sv/radio_fifo_drain_sequencer.sv
// Top level: receive FIFO drain sequencer with config registers and beat handshakes.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------------
//  cfg      | cfg_we                | cfg_index, cfg_wdata
//  in       | in_valid / in_ready   | func, busy_level, now_ms, abort_request,
//           |                       | xfer_ok, cmd_status, rx_word
//  out      | out_valid / out_ready | result_code, start_accepted, post_valid,
//           |                       | post_kind, post_opcode, post_length, error_code,
//           |                       | fifo_level, fifo_full, irq_bits
//
// Pipeline: an input beat is captured in the input register, its result is
// formed by the step logic and lands in the result register once that is free;
// one beat a cycle sustained while out_ready stays high.
// Reset: arst_n clears phase, latches, held values and config (timeout 100 ms).
// Stalls: the input register can still take a beat while a result waits; in_ready only
// drops when both the input register and the result register are occupied and out_ready is low.

module radio_fifo_drain_sequencer import rfds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	// events in
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic        busy_level,
	input  logic [31:0] now_ms,
	input  logic        abort_request,
	input  logic        xfer_ok,
	input  logic [2:0]  cmd_status,
	input  logic [31:0] rx_word,
	// results out
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  result_code,
	output logic        start_accepted,
	output logic        post_valid,
	output logic [2:0]  post_kind,
	output logic [15:0] post_opcode,
	output logic [8:0]  post_length,
	output logic [3:0]  error_code,
	output logic [8:0]  fifo_level,
	output logic        fifo_full,
	output logic [31:0] irq_bits
);

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_q;
	logic    out_valid_q;

	// input register
	logic        valid_s1;
	logic [2:0]  func_s1;
	logic        busy_s1;
	logic [31:0] now_s1;
	logic        abort_s1;
	logic        xfer_ok_s1;
	logic [2:0]  status_s1;
	logic [31:0] word_s1;

	logic res_free;
	logic step_go;

	// result register frees up this cycle if empty or being taken
	assign res_free = !out_valid_q || out_ready;
	// the beat in the input register is processed and retired
	assign step_go  = valid_s1 && res_free;
	assign in_ready = !valid_s1 || res_free;

	// config writes; unknown indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{BUSY_TIMEOUT_RST, 16'd0, 16'd0, 16'd0, 32'd0, 3'd0, 3'd0};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BUSY_TIMEOUT: cfg_q.busy_timeout <= cfg_wdata[15:0];
				REG_OP_IRQ:       cfg_q.op_irq       <= cfg_wdata[15:0];
				REG_OP_LEVEL:     cfg_q.op_level     <= cfg_wdata[15:0];
				REG_OP_READ:      cfg_q.op_read      <= cfg_wdata[15:0];
				REG_IRQ_MASK:     cfg_q.irq_mask     <= cfg_wdata;
				REG_STATUS_OK:    cfg_q.status_ok    <= cfg_wdata[2:0];
				REG_STATUS_DATA:  cfg_q.status_data  <= cfg_wdata[2:0];
				default: begin
				end
			endcase
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1    <= func;
			busy_s1    <= busy_level;
			now_s1     <= now_ms;
			abort_s1   <= abort_request;
			xfer_ok_s1 <= xfer_ok;
			status_s1  <= cmd_status;
			word_s1    <= rx_word;
		end
	end

	rfds_step u_step (
		.cfg           (cfg_q),
		.st            (state_q),
		.func          (func_s1),
		.busy_level    (busy_s1),
		.now_ms        (now_s1),
		.abort_request (abort_s1),
		.xfer_ok       (xfer_ok_s1),
		.cmd_status    (status_s1),
		.rx_word       (word_s1),
		.nxt           (state_nxt),
		.res           (res_nxt)
	);

	// sequencer state moves only when a beat retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{PH_IDLE, 32'd0, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0, 9'd0, 1'b0,
				ERR_NONE};
		end else if (step_go) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_code    = res_q.code;
	assign start_accepted = res_q.start;
	assign post_valid     = res_q.kind != KIND_NONE;
	assign post_kind      = res_q.kind;
	assign post_opcode    = res_q.opcode;
	assign post_length    = res_q.len;
	assign error_code     = res_q.err;
	assign fifo_level     = res_q.level;
	assign fifo_full      = res_q.full;
	assign irq_bits       = res_q.irq;

endmodule

### sv/rfds_checker.sv
// Port-level checker for the drain sequencer, bound to the top level.
`include "radio_fifo_drain_sequencer_assert.svh"

module rfds_checker import rfds_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  result_code,
	input logic        start_accepted,
	input logic        post_valid,
	input logic [2:0]  post_kind,
	input logic [15:0] post_opcode,
	input logic [8:0]  post_length,
	input logic [3:0]  error_code,
	input logic [8:0]  fifo_level,
	input logic        fifo_full,
	input logic [31:0] irq_bits
);

	// a stalled result beat holds
	`RFDS_ASSERT_NEXT(a_hold, out_valid && !out_ready,
		out_valid && $stable(result_code) && $stable(post_kind) &&
		$stable(post_opcode) && $stable(post_length) && $stable(irq_bits),
		"result beat changed while stalled")

	// a start beat clears the held values and posts nothing
	`RFDS_ASSERT_NOW(a_start, out_valid && start_accepted,
		result_code == RES_BUSY && error_code == ERR_NONE && fifo_level == 9'd0 &&
		!fifo_full && irq_bits == '0 && !post_valid, "start beat not clean")

	// a FIFO read frame covers the header and the held level
	`RFDS_ASSERT_NOW(a_rdlen, out_valid && post_kind == KIND_FIFO_READ,
		post_length == fifo_level + LEN_OP && fifo_level != 9'd0, "FIFO read length wrong")

	// error result always carries a cause
	`RFDS_ASSERT_NOW(a_err, out_valid && result_code == RES_ERROR,
		error_code != ERR_NONE && !post_valid, "error without cause")

	// full level is clamped to the FIFO depth
	`RFDS_ASSERT_NOW(a_full, out_valid && fifo_full, fifo_level == 9'(FIFO_DEPTH),
		"full level not clamped")

endmodule

bind radio_fifo_drain_sequencer rfds_checker u_rfds_checker (.*);
